// ----- hdl/salu_pkg.sv -----
// Shared types and constants of the signed calculator core.
// No dependencies; every other file in hdl/ imports this package.
package salu_pkg;

  localparam int unsigned RESULT_BITS = 64;
  localparam int unsigned OP_BITS     = 3;
  localparam int unsigned ERR_BITS    = 3;
  // Largest factorial argument that still fits a signed 64-bit result.
  localparam int unsigned FACT_LIMIT  = 20;
  // Bits needed to hold a factorial argument up to FACT_LIMIT.
  localparam int unsigned FACT_BITS   = 5;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_FACT = 3'd3,
    OP_DIV  = 3'd4
  } salu_op_e;

  typedef enum logic [ERR_BITS-1:0] {
    ERR_NONE     = 3'd0,
    ERR_DIV_ZERO = 3'd1,
    ERR_FACT_NEG = 3'd2,
    ERR_FACT_BIG = 3'd3,
    ERR_BAD_OP   = 3'd4
  } salu_err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FACT,
    ST_FACT_WAIT,
    ST_DIV,
    ST_HOLD
  } salu_state_e;

  // Status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } salu_stat_t;

endpackage

// ----- hdl/salu_if.sv -----
// Request and response channel interfaces of the signed calculator core.
// Depends on salu_pkg.
interface salu_req_if import salu_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 16
) ();
  logic                           valid;
  logic                           ready;
  logic        [OP_BITS-1:0]      req_type;
  logic signed [OPERAND_BITS-1:0] operand_a;
  logic signed [OPERAND_BITS-1:0] operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface salu_rsp_if import salu_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [RESULT_BITS-1:0]  result_value;
  logic signed [OPERAND_BITS-1:0] remainder;
  logic                           overflow_flag;
  logic        [ERR_BITS-1:0]     error_code;

  modport source (output valid, result_value, remainder, overflow_flag, error_code,
                  input ready);
  modport sink   (input valid, result_value, remainder, overflow_flag, error_code,
                  output ready);
endinterface

// ----- hdl/salu_mul.sv -----
// Bit-serial shift-add multiplier: one multiplier bit per cycle, 64-bit product.
// Depends on salu_pkg. Used for signed multiply and for factorial steps.
module salu_mul import salu_pkg::*; #(
  parameter int unsigned MPLIER_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [RESULT_BITS-1:0] mcand_i,
  input  logic [MPLIER_BITS-1:0] mplier_i,
  output salu_stat_t             stat_o,
  output logic [RESULT_BITS-1:0] product_o
);

  logic                   busy_q, busy_d;
  logic [RESULT_BITS-1:0] mcand_q, mcand_d;
  logic [MPLIER_BITS-1:0] mplier_q, mplier_d;
  logic [RESULT_BITS-1:0] acc_q, acc_d;
  logic                   done;
  logic                   step;

  // Finish as soon as no multiplier bits are left.
  assign done = busy_q && (mplier_q == '0);
  assign step = busy_q && (mplier_q != '0);

  always_comb begin
    busy_d   = busy_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    if (start_i) begin
      busy_d   = 1'b1;
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
      acc_d    = '0;
    end else if (step) begin
      // add the shifted multiplicand for the current multiplier bit
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done;
  assign product_o   = acc_q;

endmodule

// ----- hdl/salu_div.sv -----
// Restoring divider on magnitudes: one quotient bit per cycle.
// Depends on salu_pkg.
module salu_div import salu_pkg::*; #(
  parameter int unsigned DIV_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DIV_BITS-1:0] dividend_i,
  input  logic [DIV_BITS-1:0] divisor_i,
  output salu_stat_t          stat_o,
  output logic [DIV_BITS-1:0] quotient_o,
  output logic [DIV_BITS-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(DIV_BITS + 1);

  logic                busy_q, busy_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DIV_BITS-1:0] quo_q, quo_d;
  logic [DIV_BITS-1:0] rem_q, rem_d;
  logic [DIV_BITS-1:0] dvsr_q, dvsr_d;
  logic [DIV_BITS:0]   rem_sh;
  logic [DIV_BITS+1:0] trial;
  logic                ge;
  logic                done;

  assign done = busy_q && (cnt_q == '0);

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign rem_sh = {rem_q, quo_q[DIV_BITS-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvsr_q};
  assign ge     = !trial[DIV_BITS+1];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DIV_BITS);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvsr_d = divisor_i;
    end else if (busy_q && (cnt_q != '0)) begin
      // dividend bits shift out at the top, quotient bits in at the bottom
      rem_d = ge ? trial[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
      quo_d = {quo_q[DIV_BITS-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule

// ----- hdl/signed_alu_mul_div_factorial_core.sv -----
// Signed calculator core: add, subtract, multiply, factorial, divide.
// Depends on salu_pkg, salu_if, salu_mul and salu_div.
//
// Usage: a request on req_i (valid/ready) carries an operation code and two
// signed OPERAND_BITS-bit operands; exactly one response leaves on rsp_o with
// a 64-bit signed value, a remainder, an overflow flag and an error code.
// One request is worked on at a time; req_i.ready is high while the core is
// idle. A finished response sits in an output register, so the next request
// is taken while the receiver still stalls the previous response.
// Add, subtract, errors and invalid codes go straight to the hold state;
// multiply runs the serial multiplier, which stops once no bits of |operand_b|
// are left; divide runs the serial divider, one quotient bit per cycle;
// factorial of n does one multiplication per factor, from n down to 2, on
// the shared serial multiplier.
// Reset clears the control state and the output valid; no request or
// response is pending after reset. A stalled response holds its payload; a
// following result waits in the hold state until the output register frees up.
module signed_alu_mul_div_factorial_core import salu_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  salu_req_if.sink    req_i,
  salu_rsp_if.source  rsp_o
);

  localparam int unsigned N    = OPERAND_BITS;
  localparam int unsigned MulW = (OPERAND_BITS > FACT_BITS) ? OPERAND_BITS : FACT_BITS;

  salu_state_e            state_q, state_d;
  logic [RESULT_BITS-1:0] res_val_q, res_val_d;
  logic [N-1:0]           res_rem_q, res_rem_d;
  logic                   res_ovf_q, res_ovf_d;
  salu_err_e              res_err_q, res_err_d;
  logic                   neg_q, neg_d;
  logic                   rem_neg_q, rem_neg_d;
  logic [FACT_BITS-1:0]   fact_n_q, fact_n_d;

  logic                   out_valid_q, out_valid_d;
  logic [RESULT_BITS-1:0] out_val_q;
  logic [N-1:0]           out_rem_q;
  logic                   out_ovf_q;
  salu_err_e              out_err_q;
  logic                   out_load;

  logic [N-1:0]           a_mag, b_mag;
  logic signed [N:0]      add_a, add_b, sum_ext;
  logic [RESULT_BITS-1:0] quo_ext;

  logic                   mul_start;
  logic [RESULT_BITS-1:0] mul_mcand;
  logic [MulW-1:0]        mul_mplier;
  salu_stat_t             mul_stat;
  logic [RESULT_BITS-1:0] mul_prod;

  logic                   div_start;
  salu_stat_t             div_stat;
  logic [N-1:0]           div_quo, div_rem;

  // Operand magnitudes and the narrow add/subtract path.
  assign a_mag   = req_i.operand_a[N-1] ? (~req_i.operand_a + 1'b1) : req_i.operand_a;
  assign b_mag   = req_i.operand_b[N-1] ? (~req_i.operand_b + 1'b1) : req_i.operand_b;
  assign add_a   = {req_i.operand_a[N-1], req_i.operand_a};
  assign add_b   = {req_i.operand_b[N-1], req_i.operand_b};
  assign sum_ext = (req_i.req_type == OP_SUB) ? (add_a - add_b) : (add_a + add_b);
  assign quo_ext = RESULT_BITS'(div_quo);

  assign req_i.ready = (state_q == ST_IDLE);

  salu_mul #(
    .MPLIER_BITS (MulW)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (mul_mcand),
    .mplier_i  (mul_mplier),
    .stat_o    (mul_stat),
    .product_o (mul_prod)
  );

  salu_div #(
    .DIV_BITS (N)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (a_mag),
    .divisor_i   (b_mag),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Sequencer: decode, run the serial units, then hand off to the output register.
  always_comb begin
    state_d    = state_q;
    res_val_d  = res_val_q;
    res_rem_d  = res_rem_q;
    res_ovf_d  = res_ovf_q;
    res_err_d  = res_err_q;
    neg_d      = neg_q;
    rem_neg_d  = rem_neg_q;
    fact_n_d   = fact_n_q;
    mul_start  = 1'b0;
    mul_mcand  = res_val_q;
    mul_mplier = MulW'(fact_n_q);
    div_start  = 1'b0;
    out_load   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          res_val_d = '0;
          res_rem_d = '0;
          res_ovf_d = 1'b0;
          res_err_d = ERR_NONE;
          state_d   = ST_HOLD;
          case (salu_op_e'(req_i.req_type))
            OP_ADD, OP_SUB: begin
              res_val_d = RESULT_BITS'(sum_ext);
            end
            OP_MUL: begin
              mul_start  = 1'b1;
              mul_mcand  = RESULT_BITS'(a_mag);
              mul_mplier = MulW'(b_mag);
              neg_d      = req_i.operand_a[N-1] ^ req_i.operand_b[N-1];
              state_d    = ST_MUL;
            end
            OP_FACT: begin
              res_val_d = RESULT_BITS'(1);
              if (req_i.operand_a[N-1]) begin
                res_err_d = ERR_FACT_NEG;
              end else if (a_mag > FACT_LIMIT) begin
                res_ovf_d = 1'b1;
                res_err_d = ERR_FACT_BIG;
              end else begin
                fact_n_d = FACT_BITS'(a_mag);
                state_d  = ST_FACT;
              end
            end
            OP_DIV: begin
              if (req_i.operand_b == '0) begin
                res_err_d = ERR_DIV_ZERO;
              end else begin
                div_start = 1'b1;
                neg_d     = req_i.operand_a[N-1] ^ req_i.operand_b[N-1];
                rem_neg_d = req_i.operand_a[N-1];
                state_d   = ST_DIV;
              end
            end
            default: begin
              res_err_d = ERR_BAD_OP;
            end
          endcase
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          res_val_d = neg_q ? -mul_prod : mul_prod;
          state_d   = ST_HOLD;
        end
      end
      // one multiplication per factor, counting the factor down to 2
      ST_FACT: begin
        if (fact_n_q <= FACT_BITS'(1)) begin
          state_d = ST_HOLD;
        end else begin
          mul_start = 1'b1;
          state_d   = ST_FACT_WAIT;
        end
      end
      ST_FACT_WAIT: begin
        if (mul_stat.done) begin
          res_val_d = mul_prod;
          fact_n_d  = fact_n_q - 1'b1;
          state_d   = ST_FACT;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_val_d = neg_q ? -quo_ext : quo_ext;
          res_rem_d = rem_neg_q ? (~div_rem + 1'b1) : div_rem;
          state_d   = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid: set on load, cleared when the response is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_val_q <= res_val_d;
    res_rem_q <= res_rem_d;
    res_ovf_q <= res_ovf_d;
    res_err_q <= res_err_d;
    neg_q     <= neg_d;
    rem_neg_q <= rem_neg_d;
    fact_n_q  <= fact_n_d;
    if (out_load) begin
      out_val_q <= res_val_q;
      out_rem_q <= res_rem_q;
      out_ovf_q <= res_ovf_q;
      out_err_q <= res_err_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.result_value  = out_val_q;
  assign rsp_o.remainder     = out_rem_q;
  assign rsp_o.overflow_flag = out_ovf_q;
  assign rsp_o.error_code    = out_err_q;

  // Checks on sequencing and result coding.
  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier restarted while busy");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_div_zero_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && (req_i.req_type == OP_DIV) && (req_i.operand_b == '0))
      |=> (res_err_q == ERR_DIV_ZERO) && (state_q == ST_HOLD))
    else $error("divide by zero not flagged");

  a_load_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q == ST_HOLD))
    else $error("response loaded outside the hold state");

  a_ovf_coding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.overflow_flag == (rsp_o.error_code == ERR_FACT_BIG)))
    else $error("overflow flag disagrees with error code");

endmodule

// ----- test/signed_alu_mul_div_factorial_core_tb.sv -----
// Testbench of the signed calculator core: directed and random requests,
// with random gaps on both channels and a long output stall.
// Depends on salu_pkg, salu_if and signed_alu_mul_div_factorial_core.
`timescale 1ns / 1ps

module signed_alu_mul_div_factorial_core_tb;
  import salu_pkg::*;

  localparam int unsigned OPERAND_BITS    = 16;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES    = 200;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam longint unsigned SIGNED64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [OP_BITS-1:0] OP_CODE_LAST = '1;
  localparam logic signed [OPERAND_BITS-1:0] OPER_MAX = {1'b0, {(OPERAND_BITS-1){1'b1}}};
  localparam logic signed [OPERAND_BITS-1:0] OPER_MIN = {1'b1, {(OPERAND_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [RESULT_BITS-1:0]  value;
    logic signed [OPERAND_BITS-1:0] remainder;
    logic                           overflow;
    salu_err_e                      error;
  } calc_result_t;

  logic clk_i;
  logic rst_ni;

  salu_req_if #(.OPERAND_BITS(OPERAND_BITS)) req_bus ();
  salu_rsp_if #(.OPERAND_BITS(OPERAND_BITS)) rsp_bus ();

  signed_alu_mul_div_factorial_core #(
    .OPERAND_BITS(OPERAND_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  calc_result_t pending_results[$];
  int unsigned  failures    = 0;
  bit           req_gaps_on = 1'b1;
  bit           rsp_gaps_on = 1'b1;
  bit           hold_wanted = 1'b0;

  // Clock, 4 ns period
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Expected response of one request
  function automatic calc_result_t compute_result(logic [OP_BITS-1:0] op,
                                                  logic signed [OPERAND_BITS-1:0] a,
                                                  logic signed [OPERAND_BITS-1:0] b);
    calc_result_t    res;
    longint          lhs, rhs, sum;
    longint unsigned mag_a, mag_b, prod, quot, rest, acc;
    res.value     = '0;
    res.remainder = '0;
    res.overflow  = 1'b0;
    res.error     = ERR_NONE;
    lhs   = a;
    rhs   = b;
    mag_a = (lhs < 0) ? -lhs : lhs;
    mag_b = (rhs < 0) ? -rhs : rhs;
    case (op)
      OP_ADD, OP_SUB: begin
        sum = (op == OP_ADD) ? lhs + rhs : lhs - rhs;
        // signed 64-bit wrap: operand signs agree (add) or differ (sub)
        if (((op == OP_ADD) == (lhs[63] == rhs[63])) && sum[63] != lhs[63] && rhs != 0)
          res.overflow = 1'b1;
        else
          res.value = sum;
      end
      OP_MUL: begin
        if (mag_a != 0 && mag_b != 0 && mag_a > SIGNED64_MAX / mag_b) begin
          res.overflow = 1'b1;
        end else begin
          prod      = mag_a * mag_b;
          res.value = ((lhs < 0) != (rhs < 0)) ? -prod : prod;
        end
      end
      OP_FACT: begin
        res.value = 1;
        if (lhs < 0) begin
          res.error = ERR_FACT_NEG;
        end else if (lhs > longint'(FACT_LIMIT)) begin
          res.overflow = 1'b1;
          res.error    = ERR_FACT_BIG;
        end else begin
          acc = 1;
          for (longint unsigned i = mag_a; i > 1; i--) acc = acc * i;
          res.value = acc;
        end
      end
      OP_DIV: begin
        if (rhs == 0) begin
          res.error = ERR_DIV_ZERO;
        end else begin
          // truncate toward zero, remainder follows the dividend
          quot          = mag_a / mag_b;
          rest          = mag_a % mag_b;
          res.value     = ((lhs < 0) != (rhs < 0)) ? -quot : quot;
          rest          = (lhs < 0) ? -rest : rest;
          res.remainder = rest[OPERAND_BITS-1:0];
        end
      end
      default: res.error = ERR_BAD_OP;
    endcase
    return res;
  endfunction

  // Drive one request from a falling edge until it is accepted
  task automatic send_request(logic [OP_BITS-1:0] op,
                              logic signed [OPERAND_BITS-1:0] a,
                              logic signed [OPERAND_BITS-1:0] b);
    if (req_gaps_on && $urandom_range(0, 5) == 0) begin
      req_bus.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    req_bus.valid     = 1'b1;
    req_bus.req_type  = op;
    req_bus.operand_a = a;
    req_bus.operand_b = b;
    do @(posedge clk_i); while (!req_bus.ready);
    pending_results.push_back(compute_result(op, a, b));
    @(negedge clk_i);
  endtask

  function automatic logic signed [OPERAND_BITS-1:0] pick_operand();
    logic signed [OPERAND_BITS-1:0] v;
    case ($urandom_range(0, 7))
      0: v = OPER_MIN;
      1: v = OPER_MAX;
      2: v = OPERAND_BITS'(int'($urandom_range(0, 16)) - 8);
      default: v = OPERAND_BITS'($urandom());
    endcase
    return v;
  endfunction

  // Random mix of operations with operands biased toward the corners
  task automatic send_random_request();
    logic [OP_BITS-1:0]             op;
    logic signed [OPERAND_BITS-1:0] a, b;
    int unsigned                    pick;
    pick = $urandom_range(0, 15);
    a    = pick_operand();
    b    = pick_operand();
    if (pick < 3) op = OP_ADD;
    else if (pick < 6) op = OP_SUB;
    else if (pick < 9) op = OP_MUL;
    else if (pick < 11) begin
      op = OP_FACT;
      // mostly arguments from 0 to FACT_LIMIT + 3, some anywhere
      if ($urandom_range(0, 3) != 0) a = OPERAND_BITS'($urandom_range(0, FACT_LIMIT + 3));
    end else if (pick < 15) begin
      op = OP_DIV;
      if ($urandom_range(0, 7) == 0) b = '0;
    end else begin
      op = OP_BITS'($urandom_range(int'(OP_DIV) + 1, int'(OP_CODE_LAST)));
    end
    send_request(op, a, b);
  endtask

  task automatic test_operation_extremes();
    send_request(OP_ADD, OPER_MAX, OPER_MAX);
    send_request(OP_ADD, OPER_MIN, OPER_MIN);
    send_request(OP_ADD, OPER_MAX, OPER_MIN);
    send_request(OP_SUB, OPER_MIN, OPER_MAX);
    send_request(OP_SUB, OPER_MAX, OPER_MIN);
    send_request(OP_MUL, OPER_MIN, OPER_MIN);
    send_request(OP_MUL, OPER_MAX, OPER_MIN);
    send_request(OP_MUL, '0, OPER_MAX);
    send_request(OP_DIV, OPER_MIN, OPERAND_BITS'(-1));
    send_request(OP_DIV, OPER_MAX, OPER_MIN);
    send_request(OP_DIV, OPERAND_BITS'(7), OPERAND_BITS'(-2));
    send_request(OP_DIV, OPERAND_BITS'(-7), OPERAND_BITS'(2));
  endtask

  task automatic test_special_cases();
    // divide by zero, factorial bounds, invalid codes
    send_request(OP_DIV, OPER_MAX, '0);
    send_request(OP_FACT, OPERAND_BITS'(-1), OPER_MAX);
    send_request(OP_FACT, OPER_MIN, '0);
    send_request(OP_FACT, OPERAND_BITS'(FACT_LIMIT + 1), '0);
    send_request(OP_FACT, OPER_MAX, OPER_MIN);
    send_request(OP_FACT, '0, '0);
    send_request(OP_FACT, OPERAND_BITS'(1), OPERAND_BITS'(-1));
    send_request(OP_FACT, OPERAND_BITS'(FACT_LIMIT), '0);
    for (int unsigned c = int'(OP_DIV) + 1; c <= int'(OP_CODE_LAST); c++)
      send_request(OP_BITS'(c), OPER_MIN, OPER_MAX);
  endtask

  task automatic test_random_requests(int unsigned count);
    repeat (count) send_random_request();
  endtask

  // Receiver holds off for a long while; requests keep coming and back up
  task automatic test_output_backpressure();
    req_gaps_on = 1'b0;
    hold_wanted = 1'b1;
    repeat (12) send_random_request();
    req_gaps_on = 1'b1;
  endtask

  // No idling on either side
  task automatic test_back_to_back();
    req_gaps_on = 1'b0;
    rsp_gaps_on = 1'b0;
    repeat (400) send_random_request();
  endtask

  // Response ready: random stall bursts and the long hold-off
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_wanted) begin
        hold_wanted   = 1'b0;
        rsp_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (rsp_gaps_on && $urandom_range(0, 5) == 0) begin
        rsp_bus.ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end else begin
        rsp_bus.ready = 1'b1;
      end
    end
  end

  // Compare every accepted response with the oldest expected one
  always @(posedge clk_i) begin
    calc_result_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response value=%0d", $time, rsp_bus.result_value);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.result_value !== want.value) begin
          $display("%0t: result_value expected %0d actual %0d",
                   $time, want.value, rsp_bus.result_value);
          failures++;
        end
        if (rsp_bus.remainder !== want.remainder) begin
          $display("%0t: remainder expected %0d actual %0d",
                   $time, want.remainder, rsp_bus.remainder);
          failures++;
        end
        if (rsp_bus.overflow_flag !== want.overflow) begin
          $display("%0t: overflow_flag expected %0b actual %0b",
                   $time, want.overflow, rsp_bus.overflow_flag);
          failures++;
        end
        if (rsp_bus.error_code !== want.error) begin
          $display("%0t: error_code expected %0d actual %0d",
                   $time, want.error, rsp_bus.error_code);
          failures++;
        end
      end
    end
  end

  // Watchdog: too long without any request or response moving
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Test sequence
  initial begin
    rst_ni            = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.req_type  = OP_ADD;
    req_bus.operand_a = '0;
    req_bus.operand_b = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_operation_extremes();
    test_special_cases();
    test_random_requests(800);
    test_output_backpressure();
    test_random_requests(400);
    test_back_to_back();

    req_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/salu_pkg.sv
hdl/salu_if.sv
hdl/salu_mul.sv
hdl/salu_div.sv
hdl/signed_alu_mul_div_factorial_core.sv
test/signed_alu_mul_div_factorial_core_tb.sv
